/* hdl/rtdc_pkg.sv */
`timescale 1ns / 1ps
// rtdc_pkg: widths, defaults and fixed-point constants of the rtd code to celsius converter
// no dependencies; used by the channel interfaces and the top level
package rtdc_pkg;

  localparam int RTD_W          = 16;
  localparam int RREF_W         = 20;
  localparam int TEMP_W         = 19;
  localparam int CODE_BITS_DEF  = 15;
  localparam int TEMP_FRAC_DEF  = 8;

  localparam logic [RREF_W-1:0] RREF_RST = 20'd43000;

  // quadratic branch: A scaled by 1e8, A^2 scaled and shifted, 4|B| term
  localparam logic [63:0] A_E8       = 64'd390830;
  localparam logic [63:0] A_E8_SQ    = 64'd152748088900;
  localparam logic [63:0] FOURB_TERM = 64'd2310000;
  localparam logic [63:0] QUAD_BASE  = A_E8_SQ << 16;
  localparam logic [63:0] A_SHIFTED  = A_E8 << 8;
  localparam logic [63:0] QUAD_HALF  = 64'd29568;
  localparam logic [63:0] QUAD_DIV   = 64'd231;

  localparam int TEMP_MAX = 262143;
  localparam int TEMP_MIN = -65536;

  // inverse polynomial in R/100, Q24
  function automatic logic signed [35:0] poly_coef(input int idx);
    logic signed [35:0] c;
    case (idx)
      0:       c = -36'sd4060421816;
      1:       c = 36'sd3729239572;
      2:       c = 36'sd433842029;
      3:       c = -36'sd80966844;
      4:       c = -36'sd47283228;
      5:       c = 36'sd25573510;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* hdl/rtdc_in_if.sv */
`timescale 1ns / 1ps
// rtdc_in_if: input channel carrying one rtd register word per transfer
// depends on rtdc_pkg
interface rtdc_in_if;
  logic                       valid;
  logic                       ready;
  logic [rtdc_pkg::RTD_W-1:0] rtd_word;

  modport source (output valid, output rtd_word, input ready);
  modport sink   (input valid, input rtd_word, output ready);
endinterface

/* hdl/rtdc_out_if.sv */
`timescale 1ns / 1ps
// rtdc_out_if: result channel carrying temperature and status flags
// depends on rtdc_pkg
interface rtdc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rtdc_pkg::TEMP_W-1:0] temperature;
  logic                               valid_res;
  logic                               saturated;

  modport source (output valid, output temperature, output valid_res, output saturated,
                  input ready);
  modport sink   (input valid, input temperature, input valid_res, input saturated,
                  output ready);
endinterface

/* hdl/rtdc_cfg_if.sv */
`timescale 1ns / 1ps
// rtdc_cfg_if: write channel for the reference resistance register
// depends on rtdc_pkg
interface rtdc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rtdc_pkg::RREF_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hdl/rtd_code_to_celsius.sv */
`timescale 1ns / 1ps
// rtd_code_to_celsius: pipelined pt100 code to celsius conversion (callendar-van dusen)
// depends on rtdc_pkg, rtdc_in_if, rtdc_out_if, rtdc_cfg_if
//
//  channel   | dir | payload                                | transfer
//  in_if     | in  | rtd_word[15:0]                         | valid & ready
//  out_if    | out | temperature[18:0], valid_res, saturated| valid & ready
//  cfg_if    | in  | data[19:0] reference resistance        | valid & ready (ready tied high)
//
// 37 register stages plus one output register; one item per cycle while the output is not stalled.
// the depth comes from the 28 square root steps of the quadratic root, one per stage.
// rst_n clears the stage valid bits and the output side; rref resets to 430.00 ohm.
// a stalled output parks one result in a skid register, then the whole pipeline holds.
module rtd_code_to_celsius #(
  parameter int CODE_BITS      = rtdc_pkg::CODE_BITS_DEF,
  parameter int TEMP_FRAC_BITS = rtdc_pkg::TEMP_FRAC_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rtdc_in_if.sink    in_if,
  rtdc_out_if.source out_if,
  rtdc_cfg_if.sink   cfg_if
);

  localparam int NSQ = 28;
  localparam int QS  = 5 + NSQ;
  localparam int NST = QS + 4;

  localparam logic [35:0] K36      = 36'(64'd10000 << CODE_BITS);
  localparam logic [63:0] FOURB_SH = rtdc_pkg::FOURB_TERM << (16 - CODE_BITS);
  localparam logic [63:0] DMAX     = rtdc_pkg::QUAD_BASE / FOURB_SH;
  localparam logic [63:0] C625     = (64'd1 << 40) / 64'd625;
  localparam logic [63:0] C231     = (64'd1 << 35) / rtdc_pkg::QUAD_DIV;

  typedef struct packed {
    logic               vld;
    logic               nz;
    logic               ge;
    logic               ovr;
    logic [35:0]        x;
    logic [32:0]        d;
    logic [39:0]        y;
    logic [62:0]        plo;
    logic [38:0]        phi;
    logic [59:0]        term;
    logic [29:0]        q0;
    logic [39:0]        m625;
    logic [29:0]        u;
    logic [53:0]        sv;
    logic [54:0]        sres;
    logic               neg;
    logic [49:0]        pph;
    logic [49:0]        ppl;
    logic signed [35:0] acc;
    logic [33:0]        mq;
    logic [61:0]        prodq;
    logic [26:0]        qq0;
    logic [34:0]        r231;
    logic [27:0]        qq;
    logic [18:0]        temp;
    logic               sat;
  } pipe_t;

  typedef struct packed {
    logic [18:0] temp;
    logic        vres;
    logic        sat;
  } res_t;

  function automatic pipe_t step(input int idx, input pipe_t p);
    pipe_t              o;
    logic [35:0]        dfull;
    logic [71:0]        qsum;
    logic [54:0]        bit_v;
    logic [54:0]        trial;
    logic [35:0]        mag;
    logic [64:0]        prod;
    logic [34:0]        rp;
    logic [27:0]        n;
    logic [40:0]        nsh;
    logic signed [35:0] tp;
    int                 k;
    o = p;
    if (idx == 2) begin
      dfull = p.x - K36;
      o.ge  = p.x >= K36;
      o.ovr = o.ge && ({28'd0, dfull} > DMAX);
      o.d   = dfull[32:0];
      o.y   = 40'(p.x) << (26 - CODE_BITS);
      o.plo = 63'(o.y[31:0]) * 63'(C625);
      o.phi = 39'(o.y[39:32]) * 39'(C625);
    end
    if (idx == 3) begin
      o.term = 60'(p.d) * 60'(FOURB_SH);
      qsum   = 72'({p.phi, 32'd0}) + 72'(p.plo);
      o.q0   = qsum[69:40];
    end
    if (idx == 4) begin
      o.sv   = p.ovr ? '0 : (54'(rtdc_pkg::QUAD_BASE) - p.term[53:0]);
      o.sres = '0;
      o.m625 = 40'(p.q0) * 40'd625;
    end
    if (idx == 5) begin
      o.u   = p.q0 + 30'((p.y - p.m625) >= 40'd625);
      o.acc = rtdc_pkg::poly_coef(5);
    end
    // square root, one result bit per stage
    if (idx >= 5 && idx < 5 + NSQ) begin
      k     = idx - 5;
      bit_v = 55'(1) << (54 - 2 * k);
      trial = p.sres + bit_v;
      if ({1'b0, p.sv} >= trial) begin
        o.sv   = p.sv - trial[53:0];
        o.sres = (p.sres >> 1) + bit_v;
      end else begin
        o.sres = p.sres >> 1;
      end
    end
    // horner steps: partial products, then round and add coefficient
    if (idx >= 6 && idx < 16) begin
      k = (idx - 6) >> 1;
      if (((idx - 6) & 1) == 0) begin
        o.neg = p.acc[35];
        mag   = p.acc[35] ? 36'(-p.acc) : 36'(p.acc);
        o.pph = 50'(mag[34:0]) * 50'(p.u[29:15]);
        o.ppl = 50'(mag[34:0]) * 50'(p.u[14:0]);
      end else begin
        prod  = 65'({p.pph, 15'd0}) + 65'(p.ppl) + (65'(1) << 29);
        rp    = prod[64:30];
        o.acc = (p.neg ? -$signed({1'b0, rp}) : $signed({1'b0, rp}))
                + rtdc_pkg::poly_coef(4 - k);
      end
    end
    if (idx == QS) begin
      n    = 28'(rtdc_pkg::A_SHIFTED) - p.sres[27:0];
      nsh  = 41'(n) << (TEMP_FRAC_BITS + 1);
      o.mq = 34'((42'(nsh) + 42'(rtdc_pkg::QUAD_HALF)) >> 8);
    end
    if (idx == QS + 1) begin
      o.prodq = 62'(p.mq) * 62'(C231);
    end
    if (idx == QS + 2) begin
      o.qq0  = p.prodq[61:35];
      o.r231 = 35'(o.qq0) * 35'(rtdc_pkg::QUAD_DIV);
    end
    if (idx == QS + 3) begin
      o.qq = 28'(p.qq0) + 28'((35'(p.mq) - p.r231) >= 35'(rtdc_pkg::QUAD_DIV));
    end
    if (idx == QS + 4) begin
      tp    = (p.acc + (36'sd1 <<< (23 - TEMP_FRAC_BITS))) >>> (24 - TEMP_FRAC_BITS);
      o.sat = 1'b0;
      if (!p.nz) begin
        o.temp = '0;
      end else if (p.ge) begin
        if (p.ovr || (p.qq > 28'(rtdc_pkg::TEMP_MAX))) begin
          o.temp = 19'(rtdc_pkg::TEMP_MAX);
          o.sat  = 1'b1;
        end else begin
          o.temp = p.qq[18:0];
        end
      end else if (tp > 36'(rtdc_pkg::TEMP_MAX)) begin
        o.temp = 19'(rtdc_pkg::TEMP_MAX);
        o.sat  = 1'b1;
      end else if (tp < 36'(rtdc_pkg::TEMP_MIN)) begin
        o.temp = 19'(rtdc_pkg::TEMP_MIN);
        o.sat  = 1'b1;
      end else begin
        o.temp = tp[18:0];
      end
    end
    return o;
  endfunction

  logic [rtdc_pkg::RREF_W-1:0] rref_r;
  logic                        en;
  logic [CODE_BITS-1:0]        code;
  pipe_t                       p_r   [1:NST];
  pipe_t                       p_nxt [1:NST];
  res_t                        last;
  res_t                        out_d_r;
  res_t                        skid_d_r;
  logic                        out_v_r;
  logic                        skid_v_r;
  logic                        push;

  // configuration register
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rref_r <= rtdc_pkg::RREF_RST;
    end else if (cfg_if.valid) begin
      rref_r <= cfg_if.data;
    end
  end

  assign en          = !skid_v_r;
  assign in_if.ready = en;
  assign code        = CODE_BITS'(in_if.rtd_word >> (16 - CODE_BITS));

  always_comb begin
    p_nxt[1]     = '0;
    p_nxt[1].vld = in_if.valid;
    p_nxt[1].nz  = code != '0;
    p_nxt[1].x   = 36'(code) * 36'(rref_r);
  end

  for (genvar i = 2; i <= NST; i++) begin : g_step
    always_comb p_nxt[i] = step(i, p_r[i-1]);
  end

  for (genvar i = 1; i <= NST; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p_r[i].vld <= 1'b0;
      end else if (en) begin
        p_r[i] <= p_nxt[i];
      end
    end
  end

  // output register with skid
  assign last.temp = p_r[NST].temp;
  assign last.vres = p_r[NST].nz;
  assign last.sat  = p_r[NST].sat;
  assign push      = en && p_r[NST].vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_if.ready) begin
      if (push) begin
        skid_v_r <= 1'b1;
        skid_d_r <= last;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      out_d_r  <= skid_d_r;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= push;
      out_d_r <= last;
    end
  end

  assign out_if.valid       = out_v_r;
  assign out_if.temperature = out_d_r.temp;
  assign out_if.valid_res   = out_d_r.vres;
  assign out_if.saturated   = out_d_r.sat;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// testbench: self-checking bench for rtd_code_to_celsius, directed table then random words
// depends on rtdc_pkg, rtdc_in_if, rtdc_out_if, rtdc_cfg_if and the rtd_code_to_celsius rtl
module testbench;

  typedef logic signed [rtdc_pkg::TEMP_W-1:0] temp_t;

  typedef struct {
    temp_t temperature;
    logic  valid_res;
    logic  saturated;
  } reading_t;

  typedef struct {
    int          rref;
    int          word;
    bit          typed;
    int          temperature;
    bit          valid_res;
    bit          saturated;
  } vector_t;

  localparam int LATENCY   = 38;
  localparam int CYCLE_CAP = 300000;
  localparam int N_RANDOM  = 540;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rtdc_in_if  in_ch ();
  rtdc_out_if out_ch ();
  rtdc_cfg_if cfg_ch ();

  rtd_code_to_celsius i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #10 clk = ~clk;

  reading_t    pending_readings[$];
  logic [19:0] rref_now = rtdc_pkg::RREF_RST;
  int          mismatches = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint scale_q30(input longint acc, input longint unsigned u);
    longint unsigned m;
    longint unsigned p;
    m = (acc < 0) ? -acc : acc;
    p = (m * u + (64'd1 << 29)) >> 30;
    return (acc < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic reading_t celsius_of(input logic [15:0] word, input logic [19:0] rref);
    longint          coef[6];
    longint unsigned code, x, k, term, root, n, q, u, biased;
    longint          acc, t;
    reading_t        r;
    coef = '{-64'sd4060421816, 64'sd3729239572, 64'sd433842029,
             -64'sd80966844, -64'sd47283228, 64'sd25573510};
    code = word >> 1;
    r.saturated = 1'b0;
    r.valid_res = 1'b1;
    if (code == 0) begin
      r.temperature = '0;
      r.valid_res = 1'b0;
      return r;
    end
    x = code * rref;
    k = 64'd10000 << 15;
    if (x >= k) begin
      term = (64'd2310000 * (x - k)) << 1;
      if (term > (64'd152748088900 << 16)) begin
        t = rtdc_pkg::TEMP_MAX;
        r.saturated = 1'b1;
      end else begin
        root = int_sqrt((64'd152748088900 << 16) - term);
        n = (64'd390830 << 8) - root;
        q = ((n << 9) + 64'd29568) / 64'd59136;
        if (q > rtdc_pkg::TEMP_MAX) begin
          t = rtdc_pkg::TEMP_MAX;
          r.saturated = 1'b1;
        end else begin
          t = q;
        end
      end
    end else begin
      u = (x << 15) / 64'd10000;
      acc = coef[5];
      for (int i = 4; i >= 0; i--) acc = scale_q30(acc, u) + coef[i];
      biased = longint'(acc + (64'sd1 << 40)) + (64'd1 << 15);
      t = longint'(biased >> 16) - (64'sd1 << 24);
      if (t > rtdc_pkg::TEMP_MAX) begin
        t = rtdc_pkg::TEMP_MAX;
        r.saturated = 1'b1;
      end else if (t < rtdc_pkg::TEMP_MIN) begin
        t = rtdc_pkg::TEMP_MIN;
        r.saturated = 1'b1;
      end
    end
    r.temperature = t[rtdc_pkg::TEMP_W-1:0];
    return r;
  endfunction

  // result side: random ready bursts, compare each transfer with the oldest expectation
  int ready_hold = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= ~out_ch.ready;
        ready_hold <= $urandom_range(1, 13);
      end else begin
        out_ch.ready <= 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_readings.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result temperature=%0d", out_ch.temperature);
        end else begin
          reading_t e;
          e = pending_readings.pop_front();
          if (e.temperature !== out_ch.temperature || e.valid_res !== out_ch.valid_res ||
              e.saturated !== out_ch.saturated) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: exp temp=%0d valid=%0b sat=%0b, got %0d %0b %0b",
                       e.temperature, e.valid_res, e.saturated,
                       out_ch.temperature, out_ch.valid_res, out_ch.saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_rref(input logic [19:0] value);
    wait_drained();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    @(negedge clk);
    while (!cfg_ch.ready) @(negedge clk);
    @(posedge clk);
    rref_now = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // holds valid across back-to-back transfers; gaps drop it for a burst
  task automatic send_word(input logic [15:0] word, input reading_t exp_reading);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.rtd_word <= word;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    pending_readings.push_back(exp_reading);
  endtask

  vector_t vectors[] = '{
    '{43000, 16'h0000, 1, 0, 0, 0},
    '{43000, 16'h0001, 1, 0, 0, 0},
    '{43000, 16'hFFFF, 0, 0, 0, 0},
    '{43000, 16'hFFFE, 0, 0, 0, 0},
    '{43000, 16'h0002, 0, 0, 0, 0},
    '{43000, 16'h1E7A, 0, 0, 0, 0},
    '{43000, 16'h3C00, 0, 0, 0, 0},
    '{43000, 16'h3D00, 0, 0, 0, 0},
    '{43000, 16'h5555, 0, 0, 0, 0},
    '{43000, 16'hAAAA, 0, 0, 0, 0},
    '{0,     16'hFFFF, 0, 0, 0, 0},
    '{0,     16'h0000, 1, 0, 0, 0},
    '{1,     16'hFFFF, 0, 0, 0, 0},
    '{1,     16'h0003, 0, 0, 0, 0},
    '{1048575, 16'hFFFF, 1, 262143, 1, 1},
    '{1048575, 16'h0ABE, 0, 0, 0, 0},
    '{1048575, 16'h0AC0, 0, 0, 0, 0},
    '{1048575, 16'h0F00, 0, 0, 0, 0},
    '{1048575, 16'h0640, 0, 0, 0, 0},
    '{1048575, 16'h0002, 0, 0, 0, 0},
    '{1048575, 16'h1200, 0, 0, 0, 0}
  };

  initial begin
    reading_t    r;
    logic [15:0] w;
    int          rrefs[7];
    in_ch.valid = 1'b0;
    in_ch.rtd_word = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      if (vectors[i].rref != rref_now) begin
        in_ch.valid <= 1'b0;
        write_rref(20'(vectors[i].rref));
      end
      if (vectors[i].typed) begin
        r.temperature = temp_t'(vectors[i].temperature);
        r.valid_res = vectors[i].valid_res;
        r.saturated = vectors[i].saturated;
      end else begin
        r = celsius_of(16'(vectors[i].word), rref_now);
      end
      send_word(16'(vectors[i].word), r);
    end

    rrefs = '{43000, 1, 1048575, $urandom_range(0, 1048575), $urandom_range(38000, 45000),
              $urandom_range(100000, 600000), 43000};
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 80 == 0) begin
        in_ch.valid <= 1'b0;
        write_rref(20'(rrefs[i / 80]));
      end
      if (i > N_RANDOM * 85 / 100) quiet = 1'b1;
      if ($urandom_range(0, 1) == 0) w = 16'($urandom());
      else w = 16'($urandom_range(0, 65535) >> $urandom_range(0, 10));
      send_word(w, celsius_of(w, rref_now));
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
